@@ rtl/core/fmbq_pkg.sv @@
// Shared request codes, status codes and cell control type for the front/middle/back queue.
package fmbq_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_MID   = 3'd1,
		REQ_PUSH_BACK  = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_POP_MID    = 3'd4,
		REQ_POP_BACK   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

	// Per-beat commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins_en;
		logic rem_en;
		logic tap_load;
		logic tap_shift;
	} cell_ctrl_t;

endpackage

@@ rtl/core/fmbq_cell.sv @@
// One queue cell: holds one entry and one tap word, shifting with its neighbors.
module fmbq_cell #(
	parameter int IDX = 0,
	parameter int PW  = 6
) (
	input  logic                    clk,
	input  fmbq_pkg::cell_ctrl_t    ctrl,
	input  logic [PW-1:0]           pos,
	input  logic [31:0]             push_value,
	input  logic [31:0]             left_value,
	input  logic [31:0]             right_value,
	input  logic [31:0]             right_tap,
	output logic [31:0]             value,
	output logic [31:0]             tap
);
	import fmbq_pkg::*;

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [31:0] value_q;
	logic [31:0] tap_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (MY_IDX == pos) begin
				value_q <= push_value;
			end else if (MY_IDX > pos) begin
				value_q <= left_value;
			end
		end else if (ctrl.rem_en) begin
			if (MY_IDX >= pos) begin
				value_q <= right_value;
			end
		end
	end

	// The tap row snapshots the entries before a removal, then walks them toward cell 0.
	always_ff @(posedge clk) begin
		if (ctrl.tap_load) begin
			tap_q <= value_q;
		end else if (ctrl.tap_shift) begin
			tap_q <= right_tap;
		end
	end

	assign value = value_q;
	assign tap   = tap_q;

endmodule

@@ rtl/core/front_middle_back_queue.sv @@
// Top level of the front/middle/back queue: request decode, cell chain and result register.
//
// Usage: requests arrive on the input channel (in_valid, in_stall, req_type, push_value)
// and each produces exactly one result beat on the output channel (out_valid, out_stall,
// pop_value, status). A beat moves at a clock edge where valid is high and stall is low.
// Entries live in a row of CAPACITY cells; an insert or removal shifts every cell past
// the position in the same cycle.
// Pushes, pops of position 0, empty pops and unused codes give a registered result in the
// cycle after acceptance, and the next request may be accepted in that same cycle.
// A pop at position p > 0 reads its value through the tap row, which moves one cell per
// cycle toward cell 0; the input stalls until the result is registered, so no other
// request is accepted while such a pop is in progress.
// When the receiver stalls a waiting result, the input stalls too; nothing is lost.
// Reset clears the entry count, the busy flag and the output valid; cell contents are
// not reset and are never read before being written.
module front_middle_back_queue #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pop_value,
	output logic [1:0]         status
);
	import fmbq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0] count_q;
	logic          busy_q;
	logic [PW-1:0] scan_q;
	logic          out_valid_q;
	logic [31:0]   pop_value_q;
	logic [1:0]    status_q;

	logic [31:0] cell_val [CAPACITY];
	logic [31:0] cell_tap [CAPACITY];

	cell_ctrl_t    ctrl;
	logic [PW-1:0] pos;
	logic          in_acc;
	logic          out_free;
	logic          res_now;
	logic [31:0]   res_val;
	logic [1:0]    res_st;
	logic          start_scan;
	logic          count_inc;
	logic          count_dec;
	logic [CW-1:0] count_m1;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign count_m1 = count_q - 1'b1;

	always_comb begin
		case (req_type)
			REQ_PUSH_MID:  pos = PW'(count_q >> 1);
			REQ_PUSH_BACK: pos = PW'(count_q);
			REQ_POP_MID:   pos = PW'(count_m1 >> 1);
			REQ_POP_BACK:  pos = PW'(count_m1);
			default:       pos = '0;
		endcase
	end

	always_comb begin
		ctrl       = '0;
		res_now    = 1'b0;
		res_val    = '0;
		res_st     = ST_OK;
		start_scan = 1'b0;
		count_inc  = 1'b0;
		count_dec  = 1'b0;
		if (busy_q) begin
			if (scan_q != '0) begin
				ctrl.tap_shift = 1'b1;
			end else if (out_free) begin
				res_now = 1'b1;
				res_val = cell_tap[0];
			end
		end else if (in_acc) begin
			res_now = 1'b1;
			unique case (req_type) inside
				REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
					if (count_q >= CAP_C) begin
						res_st = ST_FULL;
					end else begin
						ctrl.ins_en = 1'b1;
						count_inc   = 1'b1;
					end
				end
				REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
					if (count_q == '0) begin
						res_val = EMPTY_VALUE;
						res_st  = ST_EMPTY;
					end else begin
						ctrl.rem_en   = 1'b1;
						ctrl.tap_load = 1'b1;
						count_dec     = 1'b1;
						if (pos == '0) begin
							res_val = cell_val[0];
						end else begin
							res_now    = 1'b0;
							start_scan = 1'b1;
						end
					end
				end
				default: begin
					res_st = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (count_dec) begin
				count_q <= count_m1;
			end
			if (start_scan) begin
				busy_q <= 1'b1;
				scan_q <= pos;
			end else if (busy_q) begin
				if (scan_q != '0) begin
					scan_q <= scan_q - 1'b1;
				end else if (out_free) begin
					busy_q <= 1'b0;
				end
			end
			if (res_now) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_now) begin
			pop_value_q <= res_val;
			status_q    <= res_st;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [31:0] left_w;
			logic [31:0] right_w;
			logic [31:0] rtap_w;
			if (gi == 0) begin : g_first
				assign left_w = push_value;
			end else begin : g_mid_l
				assign left_w = cell_val[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_w = '0;
				assign rtap_w  = '0;
			end else begin : g_mid_r
				assign right_w = cell_val[gi+1];
				assign rtap_w  = cell_tap[gi+1];
			end
			fmbq_cell #(
				.IDX (gi),
				.PW  (PW)
			) u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.pos         (pos),
				.push_value  (push_value),
				.left_value  (left_w),
				.right_value (right_w),
				.right_tap   (rtap_w),
				.value       (cell_val[gi]),
				.tap         (cell_tap[gi])
			);
		end
	endgenerate

	assign out_valid = out_valid_q;
	assign pop_value = pop_value_q;
	assign status    = status_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count exceeds capacity");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> in_stall)
		else $error("input accepted during a tap scan");

	a_scan_continues: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && scan_q != '0 |=> busy_q && !$rose(out_valid_q))
		else $error("tap scan ended early");

	a_count_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(count_q))
		else $error("entry count changed without an accepted request");

	a_full_push_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && count_q == CAP_C && (req_type == REQ_PUSH_FRONT ||
		req_type == REQ_PUSH_MID || req_type == REQ_PUSH_BACK)
		|=> out_valid_q && status_q == ST_FULL && $stable(count_q))
		else $error("push on a full queue was not dropped");
`endif

endmodule
